// ----- sv/hybrid_log_approx_multiplier_macros.svh -----
// assertion macros for the hybrid log approximate multiplier
// expects clk and rst_n in the scope of every use
`ifndef HYBRID_LOG_APPROX_MULTIPLIER_MACROS_SVH
`define HYBRID_LOG_APPROX_MULTIPLIER_MACROS_SVH

// same-cycle implication, checked out of reset
`define HLAM_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define HLAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/hlam_pkg.sv -----
// shared types, constants and helper functions for the hybrid log multiplier
// no dependencies; every module and interface file imports this package
package hlam_pkg;

  localparam int OPW       = 16;                // operand width
  localparam int TOP       = OPW - 1;           // position of the normalised leading one
  localparam int PW        = 2 * OPW;           // product width
  localparam int LOW_W     = OPW - 2;           // bits of the low part of operand a
  localparam int HALF_SPAN = 1 << (LOW_W - 1);  // largest low part magnitude
  localparam int K_W       = $clog2(OPW);       // leading-one position width
  localparam int KL_W      = K_W + 1;           // summed exponent width
  localparam int KL_MAX    = 2 * TOP - 2;       // largest summed exponent
  localparam int PP_W      = OPW + 2;           // high digit partial product width
  localparam int MAG_W     = 2 * OPW - 2;       // antilog magnitude width
  localparam int CFG_W     = 4;

  typedef logic signed [OPW-1:0] operand_t;
  typedef logic signed [PW-1:0]  product_t;
  typedef logic [CFG_W-1:0]      trunc_t;
  typedef logic [TOP-1:0]        frac_t;
  typedef logic [K_W-1:0]        lpos_t;
  typedef logic [KL_W-1:0]       kl_t;
  typedef logic [PP_W-1:0]       pp_t;

  localparam trunc_t TRUNC_RESET = trunc_t'(4);

  // after the operand split
  typedef struct packed {
    logic  neg;
    logic  zero;
    frac_t ma;
    frac_t mb;
    pp_t   pp;
  } split_t;

  // after leading-one detection and normalisation
  typedef struct packed {
    logic  neg;
    logic  zero;
    frac_t xa;
    frac_t xb;
    lpos_t ka;
    lpos_t kb;
    pp_t   pp;
  } lod_t;

  // after the mantissa add
  typedef struct packed {
    logic  neg;
    logic  zero;
    frac_t yl;
    kl_t   kl;
    pp_t   pp;
  } mant_t;

  // highest set bit, zero gives position 0
  function automatic lpos_t lead_one(frac_t v);
    lpos_t pos;
    pos = '0;
    for (int i = 0; i < TOP; i++) begin
      if (v[i]) pos = lpos_t'(i);
    end
    return pos;
  endfunction

  // fraction bits kept for a truncation setting
  function automatic frac_t mant_keep(trunc_t w);
    frac_t keep;
    for (int i = 0; i < TOP; i++) begin
      keep[i] = (i >= OPW - int'(w));
    end
    return keep;
  endfunction

  // half-lsb compensation bit
  function automatic frac_t mant_half(trunc_t w);
    frac_t h;
    for (int i = 0; i < TOP; i++) begin
      h[i] = (i == TOP - int'(w));
    end
    return h;
  endfunction

endpackage

// ----- sv/hlam_if.sv -----
// channel interfaces: operand input, product output and configuration write
// depends on hlam_pkg for payload types
interface hlam_in_if import hlam_pkg::*; ();
  logic     valid;
  logic     ready;
  operand_t operand_a;
  operand_t operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface hlam_out_if import hlam_pkg::*; ();
  logic     valid;
  logic     ready;
  product_t approx_product;

  modport source (output valid, output approx_product, input ready);
  modport sink   (input valid, input approx_product, output ready);
endinterface

interface hlam_cfg_if import hlam_pkg::*; ();
  logic   valid;
  logic   ready;
  trunc_t trunc_width;

  modport source (output valid, output trunc_width, input ready);
  modport sink   (input valid, input trunc_width, output ready);
endinterface

// ----- sv/hlam_split.sv -----
// stage 1: splits operand a into high digit and low part, forms the exact
// high partial product and one's-complement magnitudes; uses hlam_pkg
`include "hybrid_log_approx_multiplier_macros.svh"

module hlam_split import hlam_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  operand_t operand_a,
  input  operand_t operand_b,
  output logic     out_valid,
  input  logic     out_ready,
  output split_t   out_data
);

  logic                    vld_r;
  split_t                  data_r;
  split_t                  data_nxt;
  logic [LOW_W-1:0]        low;
  logic                    wrap;
  logic signed [LOW_W:0]   lo;
  logic signed [OPW:0]     diff;
  logic signed [2:0]       hi;
  logic signed [OPW+2:0]   prod;
  pp_t                     pp;
  logic                    sa;
  logic                    sb;

  always_comb begin
    low  = operand_a[LOW_W-1:0];
    // fold the remainder into -8192..8192, the tie keeps the sign of operand a
    wrap = (low > LOW_W'(HALF_SPAN)) ||
           ((low == LOW_W'(HALF_SPAN)) && operand_a[OPW-1]);
    lo   = {wrap, low};
    diff = {operand_a[OPW-1], operand_a} - {{(OPW-LOW_W){lo[LOW_W]}}, lo};
    hi   = diff[OPW:LOW_W];
    prod = hi * operand_b;
    pp   = prod[PP_W-1:0];
    // negative partial product forced odd
    if (pp[PP_W-1]) pp = (pp - pp_t'(1)) | pp_t'(1);

    sa = lo[LOW_W];
    sb = operand_b[OPW-1];
    data_nxt.neg  = sa ^ sb;
    data_nxt.zero = (lo == '0) || (operand_b == '0);
    data_nxt.ma   = sa ? frac_t'(~lo) : frac_t'(lo);
    data_nxt.mb   = sb ? ~operand_b[TOP-1:0] : operand_b[TOP-1:0];
    data_nxt.pp   = pp;
  end

  assign in_ready  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  `HLAM_ASSERT_IMPLY(a_split_low_range, vld_r, data_r.ma <= frac_t'(HALF_SPAN), "low part magnitude out of range")
  `HLAM_ASSERT_IMPLY(a_split_pp_odd, vld_r && data_r.pp[PP_W-1], data_r.pp[0], "negative high product not odd")

endmodule

// ----- sv/hlam_lod.sv -----
// stage 2: leading-one detection and normalisation of both magnitudes
// uses hlam_pkg
`include "hybrid_log_approx_multiplier_macros.svh"

module hlam_lod import hlam_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  split_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output lod_t   out_data
);

  logic  vld_r;
  lod_t  data_r;
  lod_t  data_nxt;
  lpos_t ka;
  lpos_t kb;

  always_comb begin
    ka = lead_one(in_data.ma);
    kb = lead_one(in_data.mb);
    data_nxt.neg  = in_data.neg;
    data_nxt.zero = in_data.zero;
    // the leading one drops off the top, leaving the fraction
    data_nxt.xa   = in_data.ma << (lpos_t'(TOP) - ka);
    data_nxt.xb   = in_data.mb << (lpos_t'(TOP) - kb);
    data_nxt.ka   = ka;
    data_nxt.kb   = kb;
    data_nxt.pp   = in_data.pp;
  end

  assign in_ready  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  `HLAM_ASSERT_IMPLY(a_lod_ka_range, vld_r, data_r.ka <= lpos_t'(LOW_W - 1), "low part exponent too large")
  `HLAM_ASSERT_NEXT(a_lod_hold, vld_r && !out_ready, vld_r && $stable(data_r), "stalled stage lost its data")

endmodule

// ----- sv/hlam_mant.sv -----
// stage 3: mantissa truncation with half-lsb compensation, add and exponent sum
// uses hlam_pkg; takes the live truncation setting
`include "hybrid_log_approx_multiplier_macros.svh"

module hlam_mant import hlam_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  trunc_t trunc_width,
  input  logic   in_valid,
  output logic   in_ready,
  input  lod_t   in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output mant_t  out_data
);

  logic        vld_r;
  mant_t       data_r;
  mant_t       data_nxt;
  trunc_t      w;
  frac_t       keep;
  frac_t       half;
  logic [TOP:0] sum;

  always_comb begin
    // a setting of zero behaves as one
    w    = (trunc_width == '0) ? trunc_t'(1) : trunc_width;
    keep = mant_keep(w);
    half = mant_half(w);
    sum  = {1'b0, (in_data.xa & keep) | half} + {1'b0, (in_data.xb & keep) | half};
    data_nxt.neg  = in_data.neg;
    data_nxt.zero = in_data.zero;
    data_nxt.yl   = sum[TOP-1:0];
    data_nxt.kl   = kl_t'(in_data.ka) + kl_t'(in_data.kb) + kl_t'(sum[TOP]);
    data_nxt.pp   = in_data.pp;
  end

  assign in_ready  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  `HLAM_ASSERT_IMPLY(a_mant_kl_range, vld_r, data_r.kl <= kl_t'(KL_MAX), "summed exponent out of range")

endmodule

// ----- sv/hlam_antilog.sv -----
// stage 4: antilog shift, one's-complement sign and final sum into the
// output register; uses hlam_pkg
module hlam_antilog import hlam_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  mant_t    in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output product_t out_data
);

  logic                 vld_r;
  product_t             data_r;
  product_t             data_nxt;
  logic [TOP+MAG_W-1:0] sh;
  logic [MAG_W-1:0]     mag;
  logic [PW-1:0]        ext;
  logic [PW-1:0]        mit;

  always_comb begin
    sh  = (TOP + MAG_W)'({1'b1, in_data.yl}) << in_data.kl;
    mag = sh[TOP +: MAG_W];
    ext = PW'(mag);
    if (in_data.zero) begin
      mit = '0;
    end else begin
      mit = in_data.neg ? ~ext : ext;
    end
    data_nxt = product_t'({in_data.pp, LOW_W'(0)} + mit);
  end

  assign in_ready  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- sv/hybrid_log_approx_multiplier.sv -----
// top level of the hybrid log approximate multiplier
// uses hlam_pkg, the channel interfaces and the four stage modules
//
// Signed 16x16 approximate multiplier: operand a is split into a high digit
// (-2..2) whose product with b is exact, and a low part whose product with b
// comes from a Mitchell logarithmic multiplier with a truncated mantissa.
// Four register stages (split, leading-one detect, mantissa add, antilog and
// sum) hold an accepted transaction in turn on its way to a valid
// result; one transaction is accepted every cycle while the result side keeps
// up, and each stage holds its data under back-pressure. trunc_width sets the
// kept mantissa bits (0 acts as 1, reset 4); the configuration port is always
// ready and a write applies to transactions that reach the mantissa stage
// afterwards, so write it only with the pipeline empty.
module hybrid_log_approx_multiplier import hlam_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  hlam_in_if.sink     in_port,
  hlam_out_if.source  out_port,
  hlam_cfg_if.sink    cfg_port
);

  trunc_t trunc_r;
  logic   s1_valid;
  logic   s1_ready;
  split_t s1_data;
  logic   s2_valid;
  logic   s2_ready;
  lod_t   s2_data;
  logic   s3_valid;
  logic   s3_ready;
  mant_t  s3_data;

  assign cfg_port.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trunc_r <= TRUNC_RESET;
    end else if (cfg_port.valid) begin
      trunc_r <= cfg_port.trunc_width;
    end
  end

  hlam_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_port.valid),
    .in_ready  (in_port.ready),
    .operand_a (in_port.operand_a),
    .operand_b (in_port.operand_b),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  hlam_lod u_lod (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  hlam_mant u_mant (
    .clk         (clk),
    .rst_n       (rst_n),
    .trunc_width (trunc_r),
    .in_valid    (s2_valid),
    .in_ready    (s2_ready),
    .in_data     (s2_data),
    .out_valid   (s3_valid),
    .out_ready   (s3_ready),
    .out_data    (s3_data)
  );

  hlam_antilog u_antilog (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_valid),
    .in_ready  (s3_ready),
    .in_data   (s3_data),
    .out_valid (out_port.valid),
    .out_ready (out_port.ready),
    .out_data  (out_port.approx_product)
  );

endmodule
